// ===== rtl/bawb_pkg.sv =====
// ---------------------------------------------------------------------------
// BLE advertising framer package
// Shared constants, payload types and the unrolled CRC-24, whitening and
// bit-reversal functions used by the advertising framer.
// ---------------------------------------------------------------------------
package bawb_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [0:0] REG_CHANNEL_INDEX = 1'b0;

   // Packet length limits and byte counter range.
   localparam int COUNT_WIDTH = 6;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 6'd63;
   localparam logic [COUNT_WIDTH-1:0] MIN_PDU_BYTES = 6'd9;
   localparam logic [COUNT_WIDTH-1:0] MAX_PDU_BYTES = 6'd29;

   // CRC-24 in bit-reversed form.
   localparam logic [23:0] CRC_INIT = 24'hAAAAAA;
   localparam logic [23:0] CRC_TAPS = 24'hDA6000;

   // Whitening LFSR constants.
   localparam logic [6:0] CHANNEL_BASE = 7'd37;
   localparam logic [6:0] SEED_MARK = 7'h40;
   localparam logic [7:0] LFSR_TAPS = 8'h88;

   // Channel choice that selects the highest advertising channel.
   localparam logic [1:0] CHANNEL_TOP = 2'd2;

   // Number of CRC bytes that follow the last PDU byte.
   localparam logic [1:0] CRC_BYTES = 2'd3;

   // Whitening mask for one byte and the LFSR state after it.
   typedef struct packed {
      logic [7:0] mask;
      logic [6:0] lfsr;
   } whiten_type;

   // Whitening seed for an advertising channel choice; three saturates.
   function automatic logic [6:0] seed_for_channel(input logic [1:0] chan);
      logic [1:0] sat;
      sat = (chan > CHANNEL_TOP) ? CHANNEL_TOP : chan;
      return (CHANNEL_BASE + {5'd0, sat}) | SEED_MARK;
   endfunction

   // Fold one byte, least significant bit first, into the CRC register.
   function automatic logic [23:0] crc_fold(input logic [23:0] crc,
                                            input logic [7:0] data);
      logic [23:0] c;
      logic        out_bit;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         out_bit = c[0];
         c = c >> 1;
         if (out_bit != data[i]) begin
            c = c ^ CRC_TAPS;
         end
      end
      return c;
   endfunction

   // Run the whitening LFSR for eight steps, collecting the mask.
   function automatic whiten_type whiten(input logic [6:0] lfsr);
      logic [7:0] l;
      whiten_type res;
      l = {1'b0, lfsr};
      res.mask = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (l[0]) begin
            l = l ^ LFSR_TAPS;
            res.mask[i] = 1'b1;
         end
         l = {1'b0, l[7:1]};
      end
      res.lfsr = l[6:0];
      return res;
   endfunction

   // Reverse the bit order of a byte for the radio's MSB-first order.
   function automatic logic [7:0] reverse8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/bawb_req_if.sv =====
// ---------------------------------------------------------------------------
// Framer request channel
// Valid/ready channel that carries one PDU byte and its last marker.
// ---------------------------------------------------------------------------
interface bawb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pdu_byte;
   logic       is_last;

   modport source (output valid, output pdu_byte, output is_last, input ready);
   modport sink (input valid, input pdu_byte, input is_last, output ready);
endinterface

// ===== rtl/bawb_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Framer response channel
// Valid/ready channel that carries one air byte and its packet flags.
// ---------------------------------------------------------------------------
interface bawb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] air_byte;
   logic       end_of_packet;
   logic       length_error;

   modport source (output valid, output air_byte, output end_of_packet,
                   output length_error, input ready);
   modport sink (input valid, input air_byte, input end_of_packet,
                 input length_error, output ready);
endinterface

// ===== rtl/ble_adv_crc_whiten_bitswap.sv =====
// ---------------------------------------------------------------------------
// BLE advertising PDU framer
// CRC-24 generation, data whitening and bit reversal of advertising PDUs.
// ---------------------------------------------------------------------------
// The host feeds the PDU one word (byte) at a time, header first, and marks
// the final byte with is_last. Each byte leaves as one whitened, bit-reversed
// air byte; after the final byte the three CRC bytes follow, the last of them
// carrying end_of_packet and, for a PDU outside 9 to 29 bytes, length_error.
// The block takes one byte per clock cycle unless the output stalls or CRC
// bytes are being sent: the CRC fold and the eight-step whitening run
// unrolled between the state registers and the output register. After the
// final byte the request channel is held off while the CRC bytes are sent.
// The whitening seed comes from channel_index as sampled with the first byte
// of each packet; write it only while no packet is in flight.
module ble_adv_crc_whiten_bitswap (
   input  logic                                 clock,
   input  logic                                 reset,
   bawb_req_if.sink                             req_link,
   bawb_rsp_if.source                           rsp_link,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bawb_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [bawb_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [bawb_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   // Configuration and packet state.
   logic [1:0]                          channel_ff, channel_in;
   logic [23:0]                         crc_ff, crc_in;
   logic [6:0]                          lfsr_ff, lfsr_in;
   logic [bawb_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [1:0]                          drain_ff, drain_in;
   logic                                err_ff, err_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [7:0]                          rsp_byte_ff, rsp_byte_in;
   logic                                rsp_eop_ff, rsp_eop_in;
   logic                                rsp_err_ff, rsp_err_in;

   logic                                csr_write;
   logic                                csr_hit;
   logic                                draining;
   logic                                out_load;
   logic                                accept;
   logic                                emit;
   logic                                pkt_start;
   logic [6:0]                          lfsr_src;
   logic [23:0]                         crc_base;
   logic [23:0]                         crc_next;
   logic [bawb_pkg::COUNT_WIDTH-1:0]    count_next;
   logic [7:0]                          emit_byte;
   bawb_pkg::whiten_type                wht;

   // Register access: one register at word zero, always ready.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == bawb_pkg::REG_CHANNEL_INDEX);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(bawb_pkg::CSR_DATA_WIDTH-2){1'b0}}, channel_ff}
                               : '0;
   assign channel_in = csr_write ? csr_pwdata[1:0] : channel_ff;

   // Handshake: the output register frees a slot, and CRC bytes take priority.
   assign draining       = (drain_ff != 2'd0);
   assign out_load       = !rsp_valid_ff || rsp_link.ready;
   assign req_link.ready = out_load && !draining;
   assign accept         = req_link.valid && req_link.ready;
   assign emit           = accept || (draining && out_load);

   // The first byte of a packet starts from the seed and the CRC preset.
   assign pkt_start  = (count_ff == '0);
   assign lfsr_src   = (pkt_start && !draining)
                       ? bawb_pkg::seed_for_channel(channel_ff) : lfsr_ff;
   assign crc_base   = pkt_start ? bawb_pkg::CRC_INIT : crc_ff;
   assign crc_next   = bawb_pkg::crc_fold(crc_base, req_link.pdu_byte);
   assign count_next = (count_ff == bawb_pkg::COUNT_MAX)
                       ? count_ff : count_ff + 1'b1;

   // Whitening and reversal of whichever byte goes out this cycle.
   assign emit_byte  = draining ? crc_ff[7:0] : req_link.pdu_byte;
   assign wht        = bawb_pkg::whiten(lfsr_src);

   // Next state for the packet registers.
   always_comb begin
      crc_in   = crc_ff;
      lfsr_in  = lfsr_ff;
      count_in = count_ff;
      drain_in = drain_ff;
      err_in   = err_ff;
      if (accept) begin
         lfsr_in = wht.lfsr;
         crc_in  = crc_next;
         if (req_link.is_last) begin
            count_in = '0;
            drain_in = bawb_pkg::CRC_BYTES;
            err_in   = (count_next < bawb_pkg::MIN_PDU_BYTES) ||
                       (count_next > bawb_pkg::MAX_PDU_BYTES);
         end else begin
            count_in = count_next;
         end
      end else if (draining && out_load) begin
         // Shift the next CRC byte into place.
         lfsr_in  = wht.lfsr;
         crc_in   = {8'd0, crc_ff[23:8]};
         drain_in = drain_ff - 1'b1;
      end
   end

   // Next value of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eop_in   = rsp_eop_ff;
      rsp_err_in   = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_byte_in = bawb_pkg::reverse8(emit_byte ^ wht.mask);
            rsp_eop_in  = draining && (drain_ff == 2'd1);
            rsp_err_in  = draining && (drain_ff == 2'd1) && err_ff;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff   <= 2'd0;
         crc_ff       <= bawb_pkg::CRC_INIT;
         lfsr_ff      <= bawb_pkg::seed_for_channel(2'd0);
         count_ff     <= '0;
         drain_ff     <= 2'd0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         channel_ff   <= channel_in;
         crc_ff       <= crc_in;
         lfsr_ff      <= lfsr_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_eop_ff  <= rsp_eop_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_link.valid         = rsp_valid_ff;
   assign rsp_link.air_byte      = rsp_byte_ff;
   assign rsp_link.end_of_packet = rsp_eop_ff;
   assign rsp_link.length_error  = rsp_err_ff;

endmodule
